@@ hw/rtl/touch_swipe_gesture_classifier_core_macros.svh @@
// assertion macros for the gesture classifier rtl
`ifndef TOUCH_SWIPE_GESTURE_CLASSIFIER_CORE_MACROS_SVH
`define TOUCH_SWIPE_GESTURE_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define TSGC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define TSGC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/tsgc_pkg.sv @@
// shared constants and types of the touch gesture classifier
package tsgc_pkg;

   // field and register widths
   localparam int COORD_BITS_DEF = 12;
   localparam int CFG_W          = 12;
   localparam int COUNT_W        = 7;
   localparam int IMG_W          = 6;
   localparam int DIR_W          = 3;
   localparam int KIND_W         = 2;
   localparam int CSR_IDX_W      = 3;
   localparam int RSP_DATA_W     = 16;
   localparam int RSP_USED_W     = DIR_W + IMG_W + 2;

   typedef logic [KIND_W-1:0]    req_kind_type;
   typedef logic [DIR_W-1:0]     dir_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // event kinds
   localparam req_kind_type KIND_IGNORE  = 2'd0;
   localparam req_kind_type KIND_X       = 2'd1;
   localparam req_kind_type KIND_Y       = 2'd2;
   localparam req_kind_type KIND_RELEASE = 2'd3;

   // swipe directions
   localparam dir_type DIR_NONE  = 3'd0;
   localparam dir_type DIR_RIGHT = 3'd1;
   localparam dir_type DIR_LEFT  = 3'd2;
   localparam dir_type DIR_DOWN  = 3'd3;
   localparam dir_type DIR_UP    = 3'd4;

   // register indexes
   localparam csr_idx_type CSR_SWIPE_MIN_X  = 3'd0;
   localparam csr_idx_type CSR_SWIPE_MIN_Y  = 3'd1;
   localparam csr_idx_type CSR_BUTTON_MAX_X = 3'd2;
   localparam csr_idx_type CSR_BUTTON_MIN_Y = 3'd3;
   localparam csr_idx_type CSR_BUTTON_MAX_Y = 3'd4;
   localparam csr_idx_type CSR_IMAGE_COUNT  = 3'd5;

   // register reset values
   localparam logic [CFG_W-1:0]   SWIPE_MIN_X_RST  = 12'd400;
   localparam logic [CFG_W-1:0]   SWIPE_MIN_Y_RST  = 12'd120;
   localparam logic [CFG_W-1:0]   BUTTON_MAX_X_RST = 12'd100;
   localparam logic [CFG_W-1:0]   BUTTON_MIN_Y_RST = 12'd400;
   localparam logic [CFG_W-1:0]   BUTTON_MAX_Y_RST = 12'd480;
   localparam logic [COUNT_W-1:0] IMAGE_COUNT_RST  = 7'd6;
   localparam logic [COUNT_W-1:0] IMAGE_COUNT_MAX  = 7'd64;

endpackage

@@ hw/rtl/touch_swipe_gesture_classifier_core.sv @@
// touch swipe gesture classifier: top level with event register and result register
//
// Input channel req_*: one touch event per word. tuser carries the event kind
// (ignored, x sample, y sample, release), tdata carries the coordinate. Result
// channel rsp_*: one word per release with direction, image index, lamp flag and
// a lamp-toggled marker. Other events give no word. Configuration csr_*: write-only
// registers, which the user must write while the block is idle; it is not enforced.
// An accepted event is held in the event register and processed from there; a
// release writes its result into the result register, which drives rsp_*.
// Throughput: one event per cycle while no release is blocked, set by the single
// processing stage that updates the start/end point, image index and lamp state.
// When the receiver stalls, the result word holds in the output register;
// non-release events keep flowing, and a second release waits in the event
// register, after which req_tready drops until the result is taken.
// Reset (synchronous, active high) restores the register defaults, clears
// the start point flags, end point, image index and lamp, and empties both
// the event and result registers.
`include "touch_swipe_gesture_classifier_core_macros.svh"

module touch_swipe_gesture_classifier_core
   import tsgc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // event channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((COORD_BITS + 7) / 8) * 8-1:0] req_tdata,  // [COORD_BITS-1:0] coord
   input  logic [KIND_W-1:0]                    req_tuser,  // [1:0] req_type
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [2:0] direction, [8:3] image_index, [9] lamp_on, [10] lamp_toggled
   output logic [RSP_DATA_W-1:0]                rsp_tdata,
   // configuration
   input  logic                                 csr_we,
   input  logic [CSR_IDX_W-1:0]                 csr_index,
   input  logic [CFG_W-1:0]                     csr_wdata
);

   localparam int CMP_W = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;

   // configuration registers
   logic [CFG_W-1:0]   swipe_min_x_ff, swipe_min_y_ff;
   logic [CFG_W-1:0]   button_max_x_ff, button_min_y_ff, button_max_y_ff;
   logic [COUNT_W-1:0] image_count_ff;

   // event register
   logic                  evt_valid_ff, evt_valid_in;
   req_kind_type          evt_kind_ff;
   logic [COORD_BITS-1:0] evt_coord_ff;

   // gesture state
   logic [COORD_BITS-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [COORD_BITS-1:0] end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic                  x_seen_ff, x_seen_in, y_seen_ff, y_seen_in;
   logic [IMG_W-1:0]      image_ff, image_in;
   logic                  lamp_ff, lamp_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   dir_type               out_dir_ff;
   logic [IMG_W-1:0]      out_image_ff;
   logic                  out_lamp_ff, out_toggled_ff;

   // processing stage signals
   logic                  evt_advance, is_release, load_out;
   logic [COUNT_W-1:0]    eff_count, last_index, image_inc;
   logic [COORD_BITS-1:0] abs_dx, abs_dy;
   logic                  in_swipe, in_button, do_toggle;
   dir_type               dir_in;

   // the event register moves on unless it holds a release blocked by a full output
   assign is_release  = evt_kind_ff == KIND_RELEASE;
   assign evt_advance = evt_valid_ff && (!is_release || !out_valid_ff || rsp_tready);
   assign load_out    = evt_advance && is_release;
   assign req_tready  = !evt_valid_ff || evt_advance;

   assign evt_valid_in = (req_tvalid && req_tready) || (evt_valid_ff && !evt_advance);
   assign out_valid_in = load_out || (out_valid_ff && !rsp_tready);

   // image count clamped to 1..64
   always_comb begin
      if (image_count_ff == '0) begin
         eff_count = COUNT_W'(1);
      end else if (image_count_ff > IMAGE_COUNT_MAX) begin
         eff_count = IMAGE_COUNT_MAX;
      end else begin
         eff_count = image_count_ff;
      end
   end
   assign last_index = eff_count - COUNT_W'(1);
   assign image_inc  = COUNT_W'(image_ff) + COUNT_W'(1);

   // swipe magnitudes and zone checks
   assign abs_dx = (end_x_ff > start_x_ff) ? end_x_ff - start_x_ff : start_x_ff - end_x_ff;
   assign abs_dy = (end_y_ff > start_y_ff) ? end_y_ff - start_y_ff : start_y_ff - end_y_ff;
   assign in_swipe = (CMP_W'(start_x_ff) >= CMP_W'(swipe_min_x_ff)) &&
                     (CMP_W'(start_y_ff) >= CMP_W'(swipe_min_y_ff));
   assign in_button = (CMP_W'(end_x_ff) <= CMP_W'(button_max_x_ff)) &&
                      (CMP_W'(start_y_ff) >= CMP_W'(button_min_y_ff)) &&
                      (CMP_W'(end_y_ff) <= CMP_W'(button_max_y_ff));
   assign do_toggle = x_seen_ff && y_seen_ff && in_button;

   // direction of the swipe
   always_comb begin
      dir_in = DIR_NONE;
      if (x_seen_ff && y_seen_ff && in_swipe) begin
         if (abs_dx > abs_dy) begin
            dir_in = (end_x_ff > start_x_ff) ? DIR_RIGHT : DIR_LEFT;
         end else if (abs_dx < abs_dy) begin
            dir_in = (end_y_ff > start_y_ff) ? DIR_DOWN : DIR_UP;
         end
      end
   end

   // next gesture state
   always_comb begin
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      end_x_in   = end_x_ff;
      end_y_in   = end_y_ff;
      x_seen_in  = x_seen_ff;
      y_seen_in  = y_seen_ff;
      image_in   = image_ff;
      lamp_in    = lamp_ff;
      if (evt_advance) begin
         case (evt_kind_ff)
            KIND_X: begin
               if (!x_seen_ff) begin
                  start_x_in = evt_coord_ff;
                  x_seen_in  = 1'b1;
               end
               end_x_in = evt_coord_ff;
            end
            KIND_Y: begin
               if (!y_seen_ff) begin
                  start_y_in = evt_coord_ff;
                  y_seen_in  = 1'b1;
               end
               end_y_in = evt_coord_ff;
            end
            KIND_RELEASE: begin
               x_seen_in = 1'b0;
               y_seen_in = 1'b0;
               if (dir_in == DIR_RIGHT || dir_in == DIR_DOWN) begin
                  image_in = (image_ff == '0) ? last_index[IMG_W-1:0] : image_ff - IMG_W'(1);
               end else if (dir_in == DIR_LEFT || dir_in == DIR_UP) begin
                  image_in = (image_inc > last_index) ? '0 : image_inc[IMG_W-1:0];
               end
               if (do_toggle) begin
                  lamp_in = !lamp_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         swipe_min_x_ff  <= SWIPE_MIN_X_RST;
         swipe_min_y_ff  <= SWIPE_MIN_Y_RST;
         button_max_x_ff <= BUTTON_MAX_X_RST;
         button_min_y_ff <= BUTTON_MIN_Y_RST;
         button_max_y_ff <= BUTTON_MAX_Y_RST;
         image_count_ff  <= IMAGE_COUNT_RST;
         evt_valid_ff    <= 1'b0;
         out_valid_ff    <= 1'b0;
         start_x_ff      <= '0;
         start_y_ff      <= '0;
         end_x_ff        <= '0;
         end_y_ff        <= '0;
         x_seen_ff       <= 1'b0;
         y_seen_ff       <= 1'b0;
         image_ff        <= '0;
         lamp_ff         <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SWIPE_MIN_X:  swipe_min_x_ff  <= csr_wdata;
               CSR_SWIPE_MIN_Y:  swipe_min_y_ff  <= csr_wdata;
               CSR_BUTTON_MAX_X: button_max_x_ff <= csr_wdata;
               CSR_BUTTON_MIN_Y: button_min_y_ff <= csr_wdata;
               CSR_BUTTON_MAX_Y: button_max_y_ff <= csr_wdata;
               CSR_IMAGE_COUNT:  image_count_ff  <= csr_wdata[COUNT_W-1:0];
               default: begin
               end
            endcase
         end
         evt_valid_ff <= evt_valid_in;
         out_valid_ff <= out_valid_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         end_x_ff     <= end_x_in;
         end_y_ff     <= end_y_in;
         x_seen_ff    <= x_seen_in;
         y_seen_ff    <= y_seen_in;
         image_ff     <= image_in;
         lamp_ff      <= lamp_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         evt_kind_ff  <= req_tuser;
         evt_coord_ff <= req_tdata[COORD_BITS-1:0];
      end
      if (load_out) begin
         out_dir_ff     <= dir_in;
         out_image_ff   <= image_in;
         out_lamp_ff    <= lamp_in;
         out_toggled_ff <= do_toggle;
      end
   end

   // result word
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_USED_W)'(0), out_toggled_ff, out_lamp_ff,
                        out_image_ff, out_dir_ff};

   // checks
   `TSGC_ASSERT_NEXT(a_seen_clear, clock, reset, load_out, !x_seen_ff && !y_seen_ff,
      "start point flags not cleared after release")
   `TSGC_ASSERT_NEXT(a_toggle_flips, clock, reset, load_out && do_toggle,
      lamp_ff != $past(lamp_ff) && out_toggled_ff, "lamp toggle not reflected")
   `TSGC_ASSERT_NEXT(a_no_swipe_hold, clock, reset, load_out && dir_in == DIR_NONE,
      image_ff == $past(image_ff) && out_dir_ff == DIR_NONE, "image moved without swipe")
   `TSGC_ASSERT_NOW(a_ready_when_blocked, clock, reset,
      evt_valid_ff && is_release && out_valid_ff && !rsp_tready, !req_tready,
      "event accepted while release is blocked")

endmodule

@@ verif/tb.sv @@
// self-checking testbench for the touch swipe gesture classifier core
module tb;
   import tsgc_pkg::*;

   localparam int COORD_W     = COORD_BITS_DEF;
   localparam int REQ_DATA_W  = ((COORD_W + 7) / 8) * 8;
   localparam int COORD_MAX   = (1 << COORD_W) - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 195;

   // register slots with no register behind them
   localparam csr_idx_type CSR_SPARE_LO = 3'd6;
   localparam csr_idx_type CSR_SPARE_HI = 3'd7;

   // one release word, packed in rsp_tdata bit order
   typedef struct packed {
      logic             toggled;
      logic             lamp_on;
      logic [IMG_W-1:0] image;
      dir_type          dir;
   } release_word_type;

   // tracks touch state and holds the release words still to come
   class gesture_checker;
      logic [CFG_W-1:0]   swipe_min_x, swipe_min_y;
      logic [CFG_W-1:0]   button_max_x, button_min_y, button_max_y;
      logic [COUNT_W-1:0] image_count;
      logic [COORD_W-1:0] start_x, start_y, end_x, end_y;
      bit                 start_x_valid, start_y_valid;
      logic [IMG_W-1:0]   image;
      bit                 lamp;
      release_word_type   expected_releases[$];
      int                 failures;

      function new();
         swipe_min_x   = SWIPE_MIN_X_RST;
         swipe_min_y   = SWIPE_MIN_Y_RST;
         button_max_x  = BUTTON_MAX_X_RST;
         button_min_y  = BUTTON_MIN_Y_RST;
         button_max_y  = BUTTON_MAX_Y_RST;
         image_count   = IMAGE_COUNT_RST;
         start_x       = '0;
         start_y       = '0;
         end_x         = '0;
         end_y         = '0;
         start_x_valid = 1'b0;
         start_y_valid = 1'b0;
         image         = '0;
         lamp          = 1'b0;
         failures      = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [CFG_W-1:0] value);
         case (idx)
            CSR_SWIPE_MIN_X:  swipe_min_x  = value;
            CSR_SWIPE_MIN_Y:  swipe_min_y  = value;
            CSR_BUTTON_MAX_X: button_max_x = value;
            CSR_BUTTON_MIN_Y: button_min_y = value;
            CSR_BUTTON_MAX_Y: button_max_y = value;
            CSR_IMAGE_COUNT:  image_count  = value[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_event(req_kind_type kind, logic [COORD_W-1:0] value);
         release_word_type result;
         int count, dx, dy, img;
         case (kind)
            KIND_X: begin
               if (!start_x_valid) begin
                  start_x       = value;
                  start_x_valid = 1'b1;
               end
               end_x = value;
            end
            KIND_Y: begin
               if (!start_y_valid) begin
                  start_y       = value;
                  start_y_valid = 1'b1;
               end
               end_y = value;
            end
            KIND_RELEASE: begin
               result.dir     = DIR_NONE;
               result.toggled = 1'b0;
               if (start_x_valid && start_y_valid) begin
                  // count of zero acts as one, above the maximum acts as the maximum
                  count = (image_count == 0) ? 1 :
                          (image_count > IMAGE_COUNT_MAX) ? int'(IMAGE_COUNT_MAX) :
                          int'(image_count);
                  if (start_x >= swipe_min_x && start_y >= swipe_min_y) begin
                     dx = (end_x > start_x) ? end_x - start_x : start_x - end_x;
                     dy = (end_y > start_y) ? end_y - start_y : start_y - end_y;
                     if (dx > dy)
                        result.dir = (end_x > start_x) ? DIR_RIGHT : DIR_LEFT;
                     else if (dx < dy)
                        result.dir = (end_y > start_y) ? DIR_DOWN : DIR_UP;
                     // right and down step back, left and up step forward
                     img = image;
                     if (result.dir == DIR_RIGHT || result.dir == DIR_DOWN)
                        img = (img == 0) ? count - 1 : img - 1;
                     else if (result.dir == DIR_LEFT || result.dir == DIR_UP)
                        img = (img + 1 > count - 1) ? 0 : img + 1;
                     image = img[IMG_W-1:0];
                  end
                  // lamp button zone
                  if (end_x <= button_max_x && start_y >= button_min_y &&
                      end_y <= button_max_y) begin
                     lamp           = !lamp;
                     result.toggled = 1'b1;
                  end
               end
               start_x_valid  = 1'b0;
               start_y_valid  = 1'b0;
               result.image   = image;
               result.lamp_on = lamp;
               expected_releases.push_back(result);
            end
            default: ;
         endcase
      endfunction

      function void check_release(logic [RSP_DATA_W-1:0] data);
         release_word_type seen, want;
         seen = data[RSP_USED_W-1:0];
         if (expected_releases.size() == 0) begin
            $display("%0t: result word %h arrived with none expected", $time, data);
            failures++;
            return;
         end
         want = expected_releases.pop_front();
         if (seen.dir !== want.dir) begin
            $display("%0t: direction expected %0d actual %0d", $time, want.dir, seen.dir);
            failures++;
         end
         if (seen.image !== want.image) begin
            $display("%0t: image_index expected %0d actual %0d", $time, want.image,
                     seen.image);
            failures++;
         end
         if (seen.lamp_on !== want.lamp_on) begin
            $display("%0t: lamp_on expected %0d actual %0d", $time, want.lamp_on,
                     seen.lamp_on);
            failures++;
         end
         if (seen.toggled !== want.toggled) begin
            $display("%0t: lamp_toggled expected %0d actual %0d", $time, want.toggled,
                     seen.toggled);
            failures++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [11:0] coord
   logic [KIND_W-1:0]     req_tuser = KIND_IGNORE;   // [1:0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [2:0] direction, [8:3] image_index, [9] lamp_on, [10] lamp_toggled
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   csr_idx_type           csr_index = CSR_SWIPE_MIN_X;
   logic [CFG_W-1:0]      csr_wdata = '0;

   gesture_checker gestures;
   int             cycle_count = 0;
   int             events_sent = 0;
   int             rsp_hold = 0;
   bit             steady = 1'b0;

   touch_swipe_gesture_classifier_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // watch register writes and both word channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            gestures.write_reg(csr_index, csr_wdata);
         if (req_tvalid && req_tready)
            gestures.note_event(req_tuser, req_tdata[COORD_W-1:0]);
         if (rsp_tvalid && rsp_tready)
            gestures.check_release(rsp_tdata);
      end
   end

   // result receiver with short and long stalls
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (steady || $urandom_range(0, 99) < 70) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_hold = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40)) :
                    int'($urandom_range(0, 2));
         rsp_tready <= 1'b0;
      end
   end

   function automatic int pick_gap();
      int r;
      r = int'($urandom_range(0, 99));
      if (steady || r < 60)
         return 0;
      if (r < 92)
         return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 30));
   endfunction

   // coordinate near one of two thresholds, at an extreme, or anywhere
   function automatic logic [COORD_W-1:0] pick_coord(input logic [CFG_W-1:0] near_a,
                                                     input logic [CFG_W-1:0] near_b);
      int r, v;
      r = int'($urandom_range(0, 99));
      if (r < 30)
         v = int'(r < 15 ? near_a : near_b) + int'($urandom_range(0, 4)) - 2;
      else if (r < 40)
         v = (r < 35) ? 0 : COORD_MAX;
      else
         v = int'($urandom_range(0, COORD_MAX));
      if (v < 0)
         v = 0;
      if (v > COORD_MAX)
         v = COORD_MAX;
      return v[COORD_W-1:0];
   endfunction

   task automatic send_event(input req_kind_type kind, input logic [COORD_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'(value);
      do @(posedge clock); while (!req_tready);
      if (kind != KIND_IGNORE)
         events_sent++;
   endtask

   // hold off the sender until every release word is back
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (gestures.expected_releases.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic apply_settings(input logic [CFG_W-1:0] min_x, input logic [CFG_W-1:0] min_y,
                                 input logic [CFG_W-1:0] btn_x, input logic [CFG_W-1:0] btn_lo,
                                 input logic [CFG_W-1:0] btn_hi, input logic [CFG_W-1:0] count);
      write_reg(CSR_SPARE_LO, CFG_W'($urandom_range(0, COORD_MAX)));
      write_reg(CSR_SWIPE_MIN_X, min_x);
      write_reg(CSR_SWIPE_MIN_Y, min_y);
      write_reg(CSR_BUTTON_MAX_X, btn_x);
      write_reg(CSR_BUTTON_MIN_Y, btn_lo);
      write_reg(CSR_BUTTON_MAX_Y, btn_hi);
      write_reg(CSR_IMAGE_COUNT, count);
      write_reg(CSR_SPARE_HI, CFG_W'($urandom_range(0, COORD_MAX)));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic touch(input logic [COORD_W-1:0] x0, input logic [COORD_W-1:0] y0,
                        input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] y1);
      send_event(KIND_X, x0);
      send_event(KIND_Y, y0);
      send_event(KIND_X, x1);
      send_event(KIND_Y, y1);
      send_event(KIND_RELEASE, '0);
   endtask

   // well-formed touch with random content around the current thresholds
   task automatic send_touch();
      logic [COORD_W-1:0] x0, y0;
      int d, ex, ey, moves;
      x0 = pick_coord(gestures.swipe_min_x, gestures.button_max_x);
      y0 = pick_coord(gestures.swipe_min_y, gestures.button_min_y);
      if ($urandom_range(0, 1)) begin
         send_event(KIND_X, x0);
         send_event(KIND_Y, y0);
      end else begin
         send_event(KIND_Y, y0);
         send_event(KIND_X, x0);
      end
      if ($urandom_range(0, 6) == 0) begin
         // diagonal move: equal distance on both axes
         d  = int'($urandom_range(0, 200));
         ex = (int'(x0) + d <= COORD_MAX) ? int'(x0) + d : int'(x0) - d;
         ey = ($urandom_range(0, 1) && int'(y0) >= d) ? int'(y0) - d :
              (int'(y0) + d <= COORD_MAX) ? int'(y0) + d : int'(y0) - d;
         send_event(KIND_X, ex[COORD_W-1:0]);
         send_event(KIND_Y, ey[COORD_W-1:0]);
      end else begin
         moves = int'($urandom_range(0, 4));
         repeat (moves) begin
            if ($urandom_range(0, 9) == 0)
               send_event(KIND_IGNORE, COORD_W'($urandom_range(0, COORD_MAX)));
            if ($urandom_range(0, 1))
               send_event(KIND_X, pick_coord(gestures.button_max_x, gestures.swipe_min_x));
            else
               send_event(KIND_Y, pick_coord(gestures.button_max_y, gestures.button_min_y));
         end
      end
      send_event(KIND_RELEASE, COORD_W'($urandom_range(0, COORD_MAX)));
   endtask

   initial begin
      int phase, target;
      int r;
      logic [CFG_W-1:0] count;
      gestures = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed touches with reset settings
      send_event(KIND_RELEASE, '0);          // release with no start point
      send_event(KIND_X, '0);
      send_event(KIND_RELEASE, '0);          // start y missing
      touch(12'd500, 12'd200, 12'd4095, 12'd200);   // right, index wraps back
      touch(12'd4095, 12'd4095, 12'd0, 12'd4095);   // left, index wraps forward
      send_event(KIND_Y, 12'd120);           // swipe thresholds exactly
      send_event(KIND_X, 12'd400);
      send_event(KIND_Y, 12'd4095);
      send_event(KIND_RELEASE, '0);          // down
      send_event(KIND_X, 12'd600);
      send_event(KIND_Y, 12'd4095);
      send_event(KIND_Y, 12'd130);
      send_event(KIND_RELEASE, '0);          // up
      send_event(KIND_X, 12'd500);
      send_event(KIND_Y, 12'd500);
      send_event(KIND_RELEASE, '0);          // no motion
      send_event(KIND_X, 12'd0);
      send_event(KIND_Y, 12'd400);
      send_event(KIND_RELEASE, '0);          // lamp button

      // random phases, each with its own register setting
      for (phase = 0; phase < PHASES; phase++) begin
         wait_for_results();
         case (phase)
            0: apply_settings('0, '0, '0, '0, '0, '0);
            1: apply_settings('1, '1, '1, '1, '1, '1);
            2: apply_settings('0, '0, '1, '0, '1, CFG_W'(IMAGE_COUNT_MAX));
            3: apply_settings(SWIPE_MIN_X_RST, SWIPE_MIN_Y_RST, BUTTON_MAX_X_RST,
                              BUTTON_MIN_Y_RST, BUTTON_MAX_Y_RST, CFG_W'(1));
            default: begin
               r = int'($urandom_range(0, 99));
               count = (r < 10) ? '0 :
                       (r < 20) ? CFG_W'($urandom_range(65, COORD_MAX)) :
                       CFG_W'($urandom_range(1, 64));
               apply_settings(CFG_W'($urandom_range(0, 1200)),
                              CFG_W'($urandom_range(0, 1200)),
                              CFG_W'($urandom_range(0, 600)),
                              CFG_W'($urandom_range(0, 2000)),
                              CFG_W'($urandom_range(0, 2500)), count);
            end
         endcase
         steady = 1'b0;
         target = events_sent + PHASE_ITEMS;
         while (events_sent < target) begin
            if ($urandom_range(0, 59) == 0)
               steady = !steady;
            if ($urandom_range(0, 149) == 0)
               wait_for_results();
            if ($urandom_range(0, 99) < 80)
               send_touch();
            else
               send_event(req_kind_type'($urandom_range(0, 3)),
                          COORD_W'($urandom_range(0, COORD_MAX)));
         end
      end

      wait_for_results();
      if (gestures.failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
